/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the page map block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PMFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pmfa_pkg.sv */
// Package for the page map frame allocator: sizes, codes, types and helpers.
// Used by every module of the block except pmfa_ram; depends on nothing.
package pmfa_pkg;

  // Table sizes.
  localparam int PAIR_TABLE_DEPTH = 256;
  localparam int TASK_SLOTS       = 256;

  // Field widths.
  localparam int TASK_ID_W  = 8;
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 16;
  localparam int SHIFT_W    = 5;
  localparam int FRAME_W    = 25;
  localparam int CNT_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Size units.
  localparam int KB_SHIFT = 10;
  localparam int MB_SHIFT = 20;
  localparam int BYTES_W  = SIZE_W + MB_SHIFT;

  // Derived sizes for the pair table.
  localparam int PAIR_W     = TASK_ID_W + ADDR_W;
  localparam int PAIR_IDX_W = $clog2(PAIR_TABLE_DEPTH);
  localparam int PAIR_CNT_W = $clog2(PAIR_TABLE_DEPTH + 1);

  // Only task ids below 2^TASK_ID_W exist, so at most that many slots are used.
  localparam int TASK_ID_RANGE  = 1 << TASK_ID_W;
  localparam int TASK_MEM_DEPTH = (TASK_SLOTS < TASK_ID_RANGE) ? TASK_SLOTS : TASK_ID_RANGE;
  localparam int TASK_IDX_W     = $clog2(TASK_MEM_DEPTH);

  // Reset values of the configuration registers.
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = SHIFT_W'(KB_SHIFT);
  localparam logic [FRAME_W-1:0] TOTAL_FRAMES_RST = FRAME_W'(16777216);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_MISS = 2'd0,
    STATUS_HIT  = 2'd1,
    STATUS_OOM  = 2'd2,
    STATUS_FULL = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMORY_BASE  = 2'd0,
    CFG_PAGE_SHIFT   = 2'd1,
    CFG_TOTAL_FRAMES = 2'd2
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CALC,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic calc;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

  // Task id modulo the slot count, by restoring subtraction over the id bits.
  function automatic logic [TASK_IDX_W-1:0] task_slot(input logic [TASK_ID_W-1:0] id);
    int rem;
    int k;
    rem = int'(id);
    for (k = TASK_ID_W - 1; k >= 0; k--) begin
      if (rem >= (TASK_MEM_DEPTH << k)) begin
        rem = rem - (TASK_MEM_DEPTH << k);
      end
    end
    return TASK_IDX_W'(rem);
  endfunction

endpackage

/* rtl/core/pmfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the pair table and the per-task byte totals.
module pmfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/pmfa_ctrl.sv */
// Controller state machine for the page map frame allocator.
// Depends on pmfa_pkg for the state, command and status types.
module pmfa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pmfa_pkg::dp_status_t   sts,
  output pmfa_pkg::ctrl_cmd_t    cmd
);
  import pmfa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.scan_done) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SEARCH: begin
        cmd.scan = 1'b1;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/pmfa_dp.sv */
// Datapath of the page map frame allocator: configuration, pair search,
// frame arithmetic, running totals and the result register.
// Depends on pmfa_pkg and instantiates pmfa_ram twice.
module pmfa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pmfa_pkg::ctrl_cmd_t               cmd,
  output pmfa_pkg::dp_status_t              sts,
  input  logic                              cfg_wr_en,
  input  logic [pmfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmfa_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  logic [pmfa_pkg::TASK_ID_W-1:0]    in_task_id,
  input  logic [pmfa_pkg::ADDR_W-1:0]       in_logical_address,
  input  logic [pmfa_pkg::SIZE_W-1:0]       in_size_count,
  input  logic                              in_size_in_mb,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pmfa_pkg::STATUS_W-1:0]     out_status,
  output logic [pmfa_pkg::ADDR_W-1:0]       out_physical_address,
  output logic [pmfa_pkg::ADDR_W-1:0]       out_task_total_bytes,
  output logic [pmfa_pkg::ADDR_W-1:0]       out_all_total_bytes,
  output logic [pmfa_pkg::CNT_W-1:0]        out_hits_so_far,
  output logic [pmfa_pkg::CNT_W-1:0]        out_misses_so_far
);
  import pmfa_pkg::*;

  // Configuration registers.
  logic [ADDR_W-1:0]  memory_base_r;
  logic [SHIFT_W-1:0] page_shift_r;
  logic [FRAME_W-1:0] total_frames_r;

  // Persistent allocator state.
  logic [PAIR_CNT_W-1:0] pair_count_r;
  logic [FRAME_W-1:0]    next_free_r;
  logic [ADDR_W-1:0]     global_r;
  logic [CNT_W-1:0]      hit_total_r;
  logic [CNT_W-1:0]      miss_total_r;
  logic [TASK_MEM_DEPTH-1:0] task_vld_r;

  // Current request.
  logic [TASK_ID_W-1:0]  task_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [BYTES_W-1:0]    bytes_r;
  logic [TASK_IDX_W-1:0] slot_r;

  // Search pipeline.
  logic [PAIR_CNT_W-1:0] scan_idx_r;
  logic                  probe_vld_r;
  logic                  hit_r;
  logic                  scan_issue;
  logic [PAIR_W-1:0]     pair_q;

  // Frame arithmetic results.
  logic [BYTES_W-1:0] frames_r;
  logic [ADDR_W-1:0]  offset_r;
  logic [FRAME_W-1:0] avail_r;
  logic               no_free_r;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_phys_r;
  logic [ADDR_W-1:0]   out_task_r;
  logic [ADDR_W-1:0]   out_all_r;
  logic [CNT_W-1:0]    out_hits_r;
  logic [CNT_W-1:0]    out_misses_r;

  // Commit-time signals.
  logic [ADDR_W-1:0] task_q;
  logic [ADDR_W-1:0] task_cur;
  logic [ADDR_W:0]   task_sum;
  logic [ADDR_W:0]   glob_sum;
  logic [ADDR_W-1:0] task_new;
  logic [ADDR_W-1:0] glob_new;
  logic [ADDR_W-1:0] phys_sum;
  logic              table_full;
  logic              out_of_mem;
  status_t           status;
  logic              do_alloc;
  logic [BYTES_W-1:0] bytes_in;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_base_r  <= '0;
      page_shift_r   <= PAGE_SHIFT_RST;
      total_frames_r <= TOTAL_FRAMES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MEMORY_BASE:  memory_base_r  <= cfg_wr_data[ADDR_W-1:0];
        CFG_PAGE_SHIFT:   page_shift_r   <= cfg_wr_data[SHIFT_W-1:0];
        CFG_TOTAL_FRAMES: total_frames_r <= cfg_wr_data[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte size of the incoming request.
  assign bytes_in = in_size_in_mb ? (BYTES_W'(in_size_count) << MB_SHIFT)
                                  : (BYTES_W'(in_size_count) << KB_SHIFT);

  // Capture the request when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      task_r  <= in_task_id;
      addr_r  <= in_logical_address;
      bytes_r <= bytes_in;
      slot_r  <= task_slot(in_task_id);
    end
  end

  // Pair search: one table read per cycle, compared in the next cycle.
  assign scan_issue = cmd.scan && !hit_r && (scan_idx_r < pair_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      probe_vld_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.load) begin
      scan_idx_r  <= '0;
      probe_vld_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      probe_vld_r <= scan_issue;
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + PAIR_CNT_W'(1);
      end
      if (probe_vld_r && (pair_q == {task_r, addr_r})) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign sts.scan_done = !probe_vld_r && (hit_r || (scan_idx_r == pair_count_r));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Frame count, frame offset and free frames for the current request.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      frames_r  <= bytes_r >> page_shift_r;
      offset_r  <= ADDR_W'(next_free_r) << page_shift_r;
      avail_r   <= total_frames_r - next_free_r;
      no_free_r <= next_free_r >= total_frames_r;
    end
  end

  // Commit decision and saturating sums.
  assign task_cur   = task_vld_r[slot_r] ? task_q : '0;
  assign task_sum   = {1'b0, task_cur} + (ADDR_W + 1)'(bytes_r);
  assign glob_sum   = {1'b0, global_r} + (ADDR_W + 1)'(bytes_r);
  assign task_new   = task_sum[ADDR_W] ? '1 : task_sum[ADDR_W-1:0];
  assign glob_new   = glob_sum[ADDR_W] ? '1 : glob_sum[ADDR_W-1:0];
  assign phys_sum   = memory_base_r + offset_r;
  assign table_full = pair_count_r == PAIR_CNT_W'(PAIR_TABLE_DEPTH);
  assign out_of_mem = no_free_r || (frames_r > BYTES_W'(avail_r));

  always_comb begin
    priority if (hit_r) begin
      status = STATUS_HIT;
    end else if (table_full) begin
      status = STATUS_FULL;
    end else if (out_of_mem) begin
      status = STATUS_OOM;
    end else begin
      status = STATUS_MISS;
    end
  end

  assign do_alloc = cmd.commit && (status == STATUS_MISS);

  // Persistent state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r <= '0;
      next_free_r  <= '0;
      global_r     <= '0;
      hit_total_r  <= '0;
      miss_total_r <= '0;
      task_vld_r   <= '0;
    end else if (cmd.commit) begin
      if (status == STATUS_HIT && hit_total_r != '1) begin
        hit_total_r <= hit_total_r + CNT_W'(1);
      end
      if (do_alloc) begin
        pair_count_r       <= pair_count_r + PAIR_CNT_W'(1);
        next_free_r        <= next_free_r + frames_r[FRAME_W-1:0];
        global_r           <= glob_new;
        task_vld_r[slot_r] <= 1'b1;
        if (miss_total_r != '1) begin
          miss_total_r <= miss_total_r + CNT_W'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status;
      out_phys_r   <= do_alloc ? phys_sum : '0;
      out_task_r   <= do_alloc ? task_new : task_cur;
      out_all_r    <= do_alloc ? glob_new : global_r;
      out_hits_r   <= (status == STATUS_HIT && hit_total_r != '1) ?
                      hit_total_r + CNT_W'(1) : hit_total_r;
      out_misses_r <= (do_alloc && miss_total_r != '1) ?
                      miss_total_r + CNT_W'(1) : miss_total_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_physical_address = out_phys_r;
  assign out_task_total_bytes = out_task_r;
  assign out_all_total_bytes  = out_all_r;
  assign out_hits_so_far      = out_hits_r;
  assign out_misses_so_far    = out_misses_r;

  // Table of seen (task, address) pairs.
  pmfa_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_TABLE_DEPTH)
  ) u_pair_ram (
    .clk     (clk),
    .wr_en   (do_alloc),
    .wr_addr (pair_count_r[PAIR_IDX_W-1:0]),
    .wr_data ({task_r, addr_r}),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx_r[PAIR_IDX_W-1:0]),
    .rd_data (pair_q)
  );

  // Per-task byte totals; an entry without its valid bit reads as zero.
  pmfa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TASK_MEM_DEPTH)
  ) u_task_ram (
    .clk     (clk),
    .wr_en   (do_alloc),
    .wr_addr (slot_r),
    .wr_data (task_new),
    .rd_en   (cmd.load),
    .rd_addr (task_slot(in_task_id)),
    .rd_data (task_q)
  );

endmodule

/* rtl/core/page_map_frame_allocator.sv */
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   task id, logical address, size, unit
// out_      output     out_valid / out_ready status, address, totals, counts
// cfg_      input      cfg_wr_en             register index, write data
//
// After an input is accepted, the block scans the pair table, computes the frames and
// commits the result. The scan reads one stored pair per cycle through the RAM read
// port and stops early on a hit. The next input can be taken in the cycle the result
// turns valid, so the block holds one transaction at a time.
// Reset (rst_n low, synchronous) clears counters, totals and per-task valid bits at once.
// A stalled output holds its result and the block waits before committing the next one.
//
// Top level of the page map frame allocator; joins controller and datapath.
// Depends on pmfa_pkg, pmfa_ctrl, pmfa_dp and pmfa_ram.
module page_map_frame_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pmfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmfa_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pmfa_pkg::TASK_ID_W-1:0]    in_task_id,
  input  logic [pmfa_pkg::ADDR_W-1:0]       in_logical_address,
  input  logic [pmfa_pkg::SIZE_W-1:0]       in_size_count,
  input  logic                              in_size_in_mb,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pmfa_pkg::STATUS_W-1:0]     out_status,
  output logic [pmfa_pkg::ADDR_W-1:0]       out_physical_address,
  output logic [pmfa_pkg::ADDR_W-1:0]       out_task_total_bytes,
  output logic [pmfa_pkg::ADDR_W-1:0]       out_all_total_bytes,
  output logic [pmfa_pkg::CNT_W-1:0]        out_hits_so_far,
  output logic [pmfa_pkg::CNT_W-1:0]        out_misses_so_far
);
  import pmfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencing of one transaction.
  pmfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, arithmetic and result register.
  pmfa_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wr_data          (cfg_wr_data),
    .in_task_id           (in_task_id),
    .in_logical_address   (in_logical_address),
    .in_size_count        (in_size_count),
    .in_size_in_mb        (in_size_in_mb),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_physical_address (out_physical_address),
    .out_task_total_bytes (out_task_total_bytes),
    .out_all_total_bytes  (out_all_total_bytes),
    .out_hits_so_far      (out_hits_so_far),
    .out_misses_so_far    (out_misses_so_far)
  );

endmodule

/* rtl/core/pmfa_checker.sv */
// Port-level checker for the page map frame allocator, bound to the top level.
// Depends on pmfa_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module pmfa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_wr_en,
  input logic [pmfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [pmfa_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [pmfa_pkg::TASK_ID_W-1:0]    in_task_id,
  input logic [pmfa_pkg::ADDR_W-1:0]       in_logical_address,
  input logic [pmfa_pkg::SIZE_W-1:0]       in_size_count,
  input logic                              in_size_in_mb,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pmfa_pkg::STATUS_W-1:0]     out_status,
  input logic [pmfa_pkg::ADDR_W-1:0]       out_physical_address,
  input logic [pmfa_pkg::ADDR_W-1:0]       out_task_total_bytes,
  input logic [pmfa_pkg::ADDR_W-1:0]       out_all_total_bytes,
  input logic [pmfa_pkg::CNT_W-1:0]        out_hits_so_far,
  input logic [pmfa_pkg::CNT_W-1:0]        out_misses_so_far
);
  import pmfa_pkg::*;

  // A stalled result stays valid, and its status, address and overall total stay unchanged.
  `PMFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_physical_address) && $stable(out_all_total_bytes), "Stalled result changed")

  // Only one transaction is in work at a time.
  `PMFA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "Input taken while a transaction is in work")

  // Only an allocation returns a physical address.
  `PMFA_ASSERT_IMP(a_phys_zero, clk, rst_n, out_valid && (out_status != STATUS_MISS), out_physical_address == '0, "Nonzero address without allocation")

  // A hit result has counted at least one hit.
  `PMFA_ASSERT_IMP(a_hit_count, clk, rst_n, out_valid && (out_status == STATUS_HIT), out_hits_so_far != '0, "Hit reported with zero hit count")

  // An allocation result has counted at least one miss.
  `PMFA_ASSERT_IMP(a_miss_count, clk, rst_n, out_valid && (out_status == STATUS_MISS), out_misses_so_far != '0, "Allocation reported with zero miss count")

endmodule

bind page_map_frame_allocator pmfa_checker u_pmfa_checker (.*);

/* bench/tb_page_map_frame_allocator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for page_map_frame_allocator: a queue-fed driver, a monitor
// and a cycle-free predictor of the pair table, frame pointer and running totals.
// Depends on pmfa_pkg and the page_map_frame_allocator RTL.
module tb_page_map_frame_allocator;
  import pmfa_pkg::*;

  localparam logic [ADDR_W-1:0]  ADDR_MAX   = '1;
  localparam logic [FRAME_W-1:0] FRAMES_MAX = FRAME_W'(16777216);
  localparam logic [CNT_W-1:0]   COUNT_MAX  = '1;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int QUEUE_AHEAD     = 4;
  localparam int STALL_LIMIT     = 5000;

  typedef struct {
    logic [TASK_ID_W-1:0] task_id;
    logic [ADDR_W-1:0]    addr;
    logic [SIZE_W-1:0]    size_count;
    logic                 in_mb;
  } page_req_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] phys;
    logic [ADDR_W-1:0] task_total;
    logic [ADDR_W-1:0] all_total;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
  } page_result_t;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TASK_ID_W-1:0]  in_task_id = '0;
  logic [ADDR_W-1:0]     in_logical_address = '0;
  logic [SIZE_W-1:0]     in_size_count = '0;
  logic                  in_size_in_mb = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ADDR_W-1:0]     out_physical_address;
  logic [ADDR_W-1:0]     out_task_total_bytes;
  logic [ADDR_W-1:0]     out_all_total_bytes;
  logic [CNT_W-1:0]      out_hits_so_far;
  logic [CNT_W-1:0]      out_misses_so_far;

  // Predictor copy of the configuration and state.
  logic [ADDR_W-1:0]    map_base;
  logic [SHIFT_W-1:0]   map_shift;
  logic [FRAME_W-1:0]   map_frames_limit;
  logic [TASK_ID_W-1:0] pair_task [PAIR_TABLE_DEPTH];
  logic [ADDR_W-1:0]    pair_addr [PAIR_TABLE_DEPTH];
  int                   pairs_stored;
  logic [FRAME_W-1:0]   free_frame;
  logic [ADDR_W-1:0]    task_bytes [TASK_SLOTS];
  logic [ADDR_W-1:0]    all_bytes;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;

  // Stimulus and checking bookkeeping.
  page_req_t    request_q[$];
  page_result_t expected_results[$];
  page_req_t    cur_req;
  int send_idle_pct = 15;
  int recv_idle_pct = 73;
  int requests_made = 0;
  int results_seen = 0;
  int fail_count = 0;
  int settings_used = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  page_map_frame_allocator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_task_id           (in_task_id),
    .in_logical_address   (in_logical_address),
    .in_size_count        (in_size_count),
    .in_size_in_mb        (in_size_in_mb),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_physical_address (out_physical_address),
    .out_task_total_bytes (out_task_total_bytes),
    .out_all_total_bytes  (out_all_total_bytes),
    .out_hits_so_far      (out_hits_so_far),
    .out_misses_so_far    (out_misses_so_far)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Byte totals clamp at the top of the 48-bit range.
  function automatic logic [ADDR_W-1:0] add_clamped48(logic [ADDR_W-1:0] acc,
                                                      logic [63:0] bytes);
    logic [63:0] sum;
    sum = 64'(acc) + bytes;
    return (sum > 64'(ADDR_MAX)) ? ADDR_MAX : ADDR_W'(sum);
  endfunction

  // Looks the pair up, allocates frames on a miss and returns the running totals.
  function automatic page_result_t lookup_or_allocate(page_req_t req);
    page_result_t res;
    logic [63:0]  bytes;
    logic [63:0]  frames;
    logic [63:0]  avail;
    bit           found;
    found = 1'b0;
    for (int i = 0; i < pairs_stored; i++) begin
      if (pair_task[i] == req.task_id && pair_addr[i] == req.addr) found = 1'b1;
    end
    bytes = 64'(req.size_count) << (req.in_mb ? MB_SHIFT : KB_SHIFT);
    res.phys = '0;
    if (found) begin
      res.status = STATUS_HIT;
      if (hit_count != COUNT_MAX) hit_count++;
    end else if (pairs_stored >= PAIR_TABLE_DEPTH) begin
      res.status = STATUS_FULL;
    end else begin
      frames = bytes >> map_shift;
      avail = (free_frame < map_frames_limit) ? 64'(map_frames_limit - free_frame) : 64'd0;
      if (avail == 0 || frames > avail) begin
        res.status = STATUS_OOM;
      end else begin
        // Fresh pair: hand out frames from the free pointer and update totals.
        res.status = STATUS_MISS;
        res.phys = ADDR_W'(64'(map_base) + (64'(free_frame) << map_shift));
        free_frame = FRAME_W'(64'(free_frame) + frames);
        pair_task[pairs_stored] = req.task_id;
        pair_addr[pairs_stored] = req.addr;
        pairs_stored++;
        task_bytes[req.task_id] = add_clamped48(task_bytes[req.task_id], bytes);
        all_bytes = add_clamped48(all_bytes, bytes);
        if (miss_count != COUNT_MAX) miss_count++;
      end
    end
    res.task_total = task_bytes[req.task_id];
    res.all_total = all_bytes;
    res.hits = hit_count;
    res.misses = miss_count;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom_range(0, 65535)), 32'($urandom())};
  endfunction

  // Driver: presents queued requests and predicts each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, lookup_or_allocate(cur_req)};
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = request_q.pop_front();
          in_task_id <= cur_req.task_id;
          in_logical_address <= cur_req.addr;
          in_size_count <= cur_req.size_count;
          in_size_in_mb <= cur_req.in_mb;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    page_result_t got;
    page_result_t exp;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        got.status = status_t'(out_status);
        got.phys = out_physical_address;
        got.task_total = out_task_total_bytes;
        got.all_total = out_all_total_bytes;
        got.hits = out_hits_so_far;
        got.misses = out_misses_so_far;
        status_seen[out_status]++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: result with no request pending, status=%0d pa=%h",
                     out_status, out_physical_address);
          end
        end else begin
          exp = expected_results.pop_front();
          if (got.status !== exp.status || got.phys !== exp.phys ||
              got.task_total !== exp.task_total || got.all_total !== exp.all_total ||
              got.hits !== exp.hits || got.misses !== exp.misses) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result %0d expected status=%0d pa=%h task=%h all=%h hits=%0d misses=%0d",
                       results_seen, exp.status, exp.phys, exp.task_total, exp.all_total,
                       exp.hits, exp.misses);
              $display("       got      status=%0d pa=%h task=%h all=%h hits=%0d misses=%0d",
                       got.status, got.phys, got.task_total, got.all_total,
                       got.hits, got.misses);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: stops the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_request(logic [TASK_ID_W-1:0] t, logic [ADDR_W-1:0] a,
                              logic [SIZE_W-1:0] s, logic mb);
    page_req_t req;
    req.task_id = t;
    req.addr = a;
    req.size_count = s;
    req.in_mb = mb;
    while (request_q.size() >= QUEUE_AHEAD) @(posedge clk);
    request_q = {request_q, req};
    requests_made++;
  endtask

  // Waits until every request has produced its result.
  task automatic drain();
    while (results_seen < requests_made) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle.
  task automatic apply_setting(logic [ADDR_W-1:0] base, logic [SHIFT_W-1:0] shift,
                               logic [FRAME_W-1:0] frames);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MEMORY_BASE;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_index <= CFG_PAGE_SHIFT;
    cfg_wr_data <= CFG_DATA_W'(shift);
    @(posedge clk);
    cfg_index <= CFG_TOTAL_FRAMES;
    cfg_wr_data <= CFG_DATA_W'(frames);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    map_base = base;
    map_shift = shift;
    map_frames_limit = frames;
    settings_used++;
  endtask

  // Mostly repeats of known pairs and fresh pairs of modest size, with some extremes.
  task automatic random_requests(int count);
    logic [TASK_ID_W-1:0] t;
    logic [ADDR_W-1:0]    a;
    logic [SIZE_W-1:0]    s;
    int                   pick;
    int                   idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = '1;
        2, 3:    s = SIZE_W'($urandom());
        default: s = SIZE_W'($urandom_range(1, 64));
      endcase
      if (pick < 55 && pairs_stored > 0) begin
        idx = $urandom_range(0, pairs_stored - 1);
        t = pair_task[idx];
        a = pair_addr[idx];
      end else begin
        t = TASK_ID_W'($urandom());
        if (pick < 75) a = rand48();
        else if (pick < 88) a = ADDR_W'($urandom_range(0, 15));
        else a = ADDR_MAX - ADDR_W'($urandom_range(0, 15));
      end
      push_request(t, a, s, $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic logic [FRAME_W-1:0] frames_near_pointer(int spare);
    logic [FRAME_W:0] want;
    want = (FRAME_W+1)'(free_frame) + (FRAME_W+1)'(spare);
    return (want > (FRAME_W+1)'(FRAMES_MAX)) ? FRAMES_MAX : FRAME_W'(want);
  endfunction

  // Main sequence: reset, directed cases, then random phases under several settings.
  initial begin
    map_base = '0;
    map_shift = SHIFT_W'(KB_SHIFT);
    map_frames_limit = FRAMES_MAX;
    pairs_stored = 0;
    free_frame = '0;
    all_bytes = '0;
    hit_count = '0;
    miss_count = '0;
    for (int i = 0; i < TASK_SLOTS; i++) task_bytes[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero-size request, repeat hit, oversize request, field extremes.
    push_request(8'd0, '0, '0, 1'b0);
    push_request(8'd0, '0, '0, 1'b0);
    push_request(8'hFF, ADDR_MAX, '1, 1'b1);
    push_request(8'hFF, ADDR_MAX, '1, 1'b0);
    push_request(8'hFF, ADDR_MAX, 16'd7, 1'b1);
    push_request(8'd0, ADDR_MAX, 16'd1, 1'b0);
    push_request(8'hAA, 48'hAAAA_AAAA_AAAA, 16'hAAAA, 1'b0);
    push_request(8'h55, 48'h5555_5555_5555, 16'h5555, 1'b1);

    // 1 GB pages at the top of the address space: sub-page request and wrap.
    apply_setting(ADDR_MAX, 5'd30, FRAMES_MAX);
    push_request(8'd1, 48'd100, 16'd1, 1'b1);
    push_request(8'd1, 48'd101, 16'd1024, 1'b1);
    push_request(8'd1, 48'd102, '1, 1'b1);

    // Byte pages with exactly enough room, then none left even for a zero size.
    drain();
    apply_setting('0, 5'd0, frames_near_pointer(1024));
    push_request(8'd2, 48'd0, 16'd1, 1'b0);
    push_request(8'd2, 48'd1, 16'd0, 1'b0);
    push_request(8'd2, 48'd0, 16'd0, 1'b0);

    // Frame limit lowered below the free pointer: fresh pairs fail, hits still count.
    apply_setting(48'h0000_1234_5678, SHIFT_W'(KB_SHIFT), '0);
    push_request(8'd3, 48'd5, 16'd0, 1'b0);
    push_request(8'hFF, ADDR_MAX, 16'd0, 1'b0);

    apply_setting(rand48(), 5'd12, FRAMES_MAX);
    random_requests(ITEMS_PER_PHASE);
    apply_setting('0, 5'd0, FRAME_W'($urandom_range(0, 16777216)));
    random_requests(ITEMS_PER_PHASE);

    drain();
    send_idle_pct = 73;
    recv_idle_pct = 15;
    apply_setting(ADDR_MAX, 5'd20, frames_near_pointer($urandom_range(0, 64)));
    random_requests(ITEMS_PER_PHASE);
    apply_setting(rand48(), 5'd25, FRAMES_MAX);
    random_requests(ITEMS_PER_PHASE);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting('0, 5'd30, FRAMES_MAX);
    random_requests(ITEMS_PER_PHASE);
    apply_setting(rand48(), 5'd14, FRAME_W'($urandom_range(0, 16777216)));
    random_requests(ITEMS_PER_PHASE);

    drain();
    repeat (PAIR_TABLE_DEPTH + 8) @(posedge clk);

    $display("Ran %0d requests under %0d register settings; %0d pairs stored.",
             requests_made, settings_used, pairs_stored);
    $display("Results: %0d allocated, %0d hits, %0d out of memory, %0d table full.",
             status_seen[STATUS_MISS], status_seen[STATUS_HIT],
             status_seen[STATUS_OOM], status_seen[STATUS_FULL]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatching results", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
